// ===== hdl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, constants and helpers for the SD card SPI-mode sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned REG_BYTES   = 16;
  localparam int unsigned TAIL_BYTES  = 22;

  localparam logic [1:0] CFG_IDLE_RETRY  = 2'd0;
  localparam logic [1:0] CFG_READY_RETRY = 2'd1;
  localparam logic [1:0] CFG_RESP_POLL   = 2'd2;
  localparam logic [1:0] CFG_TOKEN_POLL  = 2'd3;

  localparam logic [2:0] OP_SLOT  = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_CSD   = 3'd4;
  localparam logic [2:0] OP_CID   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REJECT    = 3'd1;
  localparam logic [2:0] ST_NO_IDLE   = 3'd2;
  localparam logic [2:0] ST_VOLTAGE   = 3'd3;
  localparam logic [2:0] ST_INIT_TO   = 3'd4;
  localparam logic [2:0] ST_OCR_TO    = 3'd5;
  localparam logic [2:0] ST_TOKEN_TO  = 3'd6;

  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;

  typedef struct packed {
    logic [7:0]  idle_retry;
    logic [15:0] ready_retry;
    logic [7:0]  resp_poll;
    logic [19:0] token_poll;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sector_count;
    logic        card_is_hc;
    logic        need_tx_data;
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic [2:0]  status;
    logic        done_res;
    logic        busy_res;
    logic        cs_active;
    logic [7:0]  mosi_byte;
  } res_t;

  function automatic logic [47:0] mkframe(input logic [5:0] cmd, input logic [31:0] arg,
                                          input logic [7:0] crc);
    return {2'b01, cmd, arg, crc};
  endfunction

endpackage

// ===== hdl/sdspi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_core
// Sequencer state and single-pass next-state logic, one byte exchange per step.
// ----------------------------------------------------------------------------
module sdspi_core #(
  parameter int unsigned WAKE_BYTES = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [2:0]       opcode_i,
  input  logic [31:0]      block_addr_i,
  input  logic [7:0]       miso_i,
  input  logic [7:0]       tx_data_i,
  input  sdspi_pkg::cfg_t  cfg_i,
  output sdspi_pkg::res_t  res_o,
  output logic             rx_last_o
);
  import sdspi_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_SEL, PH_CMD, PH_POLL, PH_TRAIL, PH_TOKEN, PH_RX,
    PH_WDATA, PH_WTAIL, PH_BUSY
  } phase_e;

  typedef enum logic [3:0] {
    K_GOIDLE, K_IFCOND, K_OCR1, K_APP, K_OPCOND, K_OCR2, K_BLKLEN, K_CSDI,
    K_REG, K_READ, K_WRITE
  } ctx_e;

  localparam logic [9:0] WAKE_N  = 10'(WAKE_BYTES);
  localparam logic [9:0] BLK_N   = 10'(BLOCK_BYTES);
  localparam logic [9:0] REG_N   = 10'(REG_BYTES);
  localparam logic [9:0] TAIL_N  = 10'(TAIL_BYTES);

  phase_e      phase_q, phase_d;
  ctx_e        ctx_q, ctx_d;
  logic [15:0] try_q, try_d;
  logic [19:0] poll_q, poll_d;
  logic [9:0]  bi_q, bi_d;
  logic [47:0] frame_q, frame_d;
  logic [7:0]  csd_q [6];
  logic [7:0]  csd_d [6];
  logic        hc_q, hc_d, rech_q, rech_d, v2_q, v2_d, echo_q, echo_d;
  logic [2:0]  init_q, init_d;
  logic [31:0] sect_q, sect_d;

  function automatic logic [31:0] csd_sectors(input logic v2, input logic [7:0] f0,
      input logic [7:0] f1, input logic [7:0] f2, input logic [7:0] f3,
      input logic [7:0] f4, input logic [7:0] f5);
    logic [22:0] n;
    logic [12:0] size;
    logic [4:0]  mult;
    logic [27:0] big;
    if (v2) begin
      n = {1'b0, f2[5:0], f3, f4} + 23'd1;
      if (n[22]) return 32'hFFFF_FFFF;
      return {n[21:0], 10'd0};
    end
    size = {1'b0, f1[1:0], f2, f3[7:6]} + 13'd1;
    mult = {2'b00, f4[1:0], f5[7]} + 5'd2 + {1'b0, f0[3:0]};
    big  = {15'd0, size};
    if (mult >= 5'd9) big = big << (mult - 5'd9);
    else big = big >> (5'd9 - mult);
    return {4'd0, big};
  endfunction

  always_comb begin
    logic        do_start, do_csdi, do_rech, do_app, do_fin;
    ctx_e        sk;
    logic [47:0] sf;
    logic [2:0]  fcode;
    logic [9:0]  j, payload;
    logic [15:0] try_inc;
    logic [31:0] addr;
    logic        poll_hit, tok_hit;
    phase_d = phase_q; ctx_d = ctx_q; try_d = try_q; poll_d = poll_q; bi_d = bi_q;
    frame_d = frame_q; csd_d = csd_q; hc_d = hc_q; rech_d = rech_q; v2_d = v2_q;
    echo_d = echo_q; init_d = init_q; sect_d = sect_q;
    res_o = '0; res_o.mosi_byte = IDLE_BYTE; rx_last_o = 1'b0;
    do_start = 1'b0; do_csdi = 1'b0; do_rech = 1'b0; do_app = 1'b0; do_fin = 1'b0;
    sk = K_GOIDLE; sf = '0; fcode = ST_OK;
    j = bi_q - 10'd1;
    payload = (ctx_q == K_READ) ? BLK_N : REG_N;
    try_inc = try_q + 16'd1;
    addr = hc_q ? block_addr_i : {block_addr_i[22:0], 9'd0};
    poll_hit = (poll_q >= {12'd0, (cfg_i.resp_poll == 8'd0) ? 8'd1 : cfg_i.resp_poll});
    tok_hit = (cfg_i.token_poll != 20'd0) && (poll_q >= cfg_i.token_poll);

    unique case (phase_q)
      PH_IDLE: begin
        unique case (opcode_i)
          OP_INIT: begin
            init_d = ST_OK; try_d = '0; ctx_d = K_GOIDLE;
            frame_d = mkframe(6'd0, 32'd0, 8'h95); bi_d = '0; phase_d = PH_WAKE;
            res_o.busy_res = 1'b1;
          end
          OP_READ, OP_WRITE: begin
            ctx_d = (opcode_i == OP_READ) ? K_READ : K_WRITE;
            frame_d = mkframe((opcode_i == OP_READ) ? 6'd17 : 6'd24, addr, 8'hFF);
            phase_d = PH_SEL; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
          end
          OP_CSD, OP_CID: begin
            ctx_d = K_REG;
            frame_d = mkframe((opcode_i == OP_CSD) ? 6'd9 : 6'd10, 32'd0, 8'hFF);
            phase_d = PH_SEL; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
          end
          default: ;
        endcase
      end
      PH_WAKE: begin
        res_o.busy_res = 1'b1;
        if (bi_q < WAKE_N) bi_d = bi_q + 10'd1;
        else begin
          phase_d = PH_SEL; res_o.cs_active = 1'b1;
        end
      end
      PH_SEL: begin
        do_start = 1'b1; sk = ctx_q; sf = frame_q;
      end
      PH_CMD: begin
        res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        if (bi_q < 10'd6) begin
          res_o.mosi_byte = frame_q[(3'd5 - bi_q[2:0]) * 8 +: 8];
          bi_d = bi_q + 10'd1;
        end else begin
          poll_d = 20'd1; phase_d = PH_POLL;
        end
      end
      PH_POLL: begin
        if (miso_i != IDLE_BYTE || poll_hit) begin
          unique case (ctx_q)
            K_GOIDLE: begin
              if (miso_i == 8'h01) begin
                do_start = 1'b1; sk = K_IFCOND; sf = mkframe(6'd8, 32'h1AA, 8'h87);
              end else begin
                try_d = try_inc;
                if (try_inc >= {8'd0, (cfg_i.idle_retry == 8'd0) ? 8'd1 : cfg_i.idle_retry})
                begin
                  init_d = ST_NO_IDLE; do_csdi = 1'b1;
                end else begin
                  do_start = 1'b1; sk = K_GOIDLE; sf = mkframe(6'd0, 32'd0, 8'h95);
                end
              end
            end
            K_IFCOND: begin
              if (!miso_i[2]) begin
                echo_d = 1'b1; bi_d = 10'd1; phase_d = PH_TRAIL;
                res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
              end else begin
                hc_d = 1'b0; rech_d = 1'b0;
                do_start = 1'b1; sk = K_OCR1; sf = mkframe(6'd58, 32'd0, 8'hFF);
              end
            end
            K_OCR1, K_OCR2: begin
              bi_d = 10'd1; phase_d = PH_TRAIL;
              res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
            end
            K_APP: begin
              do_start = 1'b1; sk = K_OPCOND; sf = mkframe(6'd41, 32'h4000_0000, 8'hFF);
            end
            K_OPCOND: begin
              if (!miso_i[0]) do_rech = 1'b1;
              else begin
                try_d = try_inc;
                if (try_inc >= ((cfg_i.ready_retry == 16'd0) ? 16'd1 : cfg_i.ready_retry))
                begin
                  init_d = ST_INIT_TO; do_csdi = 1'b1;
                end else do_app = 1'b1;
              end
            end
            K_BLKLEN: begin
              init_d = ST_OK; do_csdi = 1'b1;
            end
            K_CSDI: begin
              if (miso_i != 8'h00) begin
                sect_d = '0; do_fin = 1'b1; fcode = init_q;
              end else begin
                poll_d = 20'd1; phase_d = PH_TOKEN;
                res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
              end
            end
            K_WRITE: begin
              if (miso_i != 8'h00) begin
                do_fin = 1'b1; fcode = ST_REJECT;
              end else begin
                bi_d = '0; phase_d = PH_WDATA; res_o.mosi_byte = TOKEN_START;
                res_o.busy_res = 1'b1; res_o.cs_active = 1'b1; res_o.need_tx_data = 1'b1;
              end
            end
            default: begin
              if (miso_i != 8'h00) begin
                do_fin = 1'b1; fcode = ST_REJECT;
              end else begin
                poll_d = 20'd1; phase_d = PH_TOKEN;
                res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
              end
            end
          endcase
        end else begin
          poll_d = poll_q + 20'd1; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (ctx_q == K_IFCOND) begin
          if (j == 10'd2 && !miso_i[0]) echo_d = 1'b0;
          if (j == 10'd3 && miso_i != 8'hAA) echo_d = 1'b0;
        end else if (ctx_q == K_OCR1 && j == 10'd0) begin
          if (miso_i[7]) begin
            hc_d = miso_i[6]; rech_d = 1'b0;
          end else rech_d = 1'b1;
        end else if (ctx_q == K_OCR2 && j == 10'd0) begin
          hc_d = miso_i[6]; rech_d = !miso_i[7];
        end
        if (bi_q < 10'd4) begin
          bi_d = bi_q + 10'd1; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        end else if (ctx_q == K_IFCOND) begin
          if (echo_d) begin
            hc_d = 1'b0; rech_d = 1'b0;
            do_start = 1'b1; sk = K_OCR1; sf = mkframe(6'd58, 32'd0, 8'hFF);
          end else begin
            init_d = ST_VOLTAGE; do_csdi = 1'b1;
          end
        end else if (ctx_q == K_OCR1) begin
          try_d = '0; do_app = 1'b1;
        end else do_rech = 1'b1;
      end
      PH_TOKEN: begin
        if (miso_i == TOKEN_START) begin
          bi_d = 10'd1; phase_d = PH_RX; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        end else if (tok_hit) begin
          do_fin = 1'b1;
          if (ctx_q == K_CSDI) begin
            sect_d = '0; fcode = (init_q != ST_OK) ? init_q : ST_TOKEN_TO;
          end else fcode = ST_TOKEN_TO;
        end else begin
          poll_d = poll_q + 20'd1; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        end
      end
      PH_RX: begin
        if (ctx_q == K_CSDI) begin
          if (j == 10'd0) v2_d = miso_i[6];
          if (j >= 10'd5 && j <= 10'd10) csd_d[3'(j - 10'd5)] = miso_i;
        end else if (j < payload) begin
          res_o.rx_valid = 1'b1; res_o.rx_byte = miso_i;
          rx_last_o = (j == payload - 10'd1);
        end
        if (bi_q < payload + 10'd2) begin
          bi_d = bi_q + 10'd1; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        end else if (ctx_q == K_CSDI) begin
          sect_d = csd_sectors(v2_q, csd_q[0], csd_q[1], csd_q[2], csd_q[3], csd_q[4],
                               csd_q[5]);
          do_fin = 1'b1; fcode = init_q;
        end else begin
          do_fin = 1'b1; fcode = ST_OK;
        end
      end
      PH_WDATA: begin
        res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        if (bi_q < BLK_N) begin
          bi_d = bi_q + 10'd1; res_o.mosi_byte = tx_data_i;
          res_o.need_tx_data = (bi_q + 10'd1 < BLK_N);
        end else begin
          bi_d = 10'd1; phase_d = PH_WTAIL;
        end
      end
      PH_WTAIL: begin
        res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        if (bi_q < TAIL_N) bi_d = bi_q + 10'd1;
        else begin
          poll_d = 20'd1; phase_d = PH_BUSY;
        end
      end
      PH_BUSY: begin
        if (miso_i == IDLE_BYTE) begin
          do_fin = 1'b1; fcode = ST_OK;
        end else if (tok_hit) begin
          do_fin = 1'b1; fcode = ST_TOKEN_TO;
        end else begin
          poll_d = poll_q + 20'd1; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    if (do_rech) begin
      if (rech_d) begin
        if (try_q >= ((cfg_i.ready_retry == 16'd0) ? 16'd1 : cfg_i.ready_retry)) begin
          init_d = ST_OCR_TO; do_csdi = 1'b1;
        end else begin
          try_d = try_inc; do_start = 1'b1; sk = K_OCR2; sf = mkframe(6'd58, 32'd0, 8'hFF);
        end
      end else if (!hc_d) begin
        do_start = 1'b1; sk = K_BLKLEN; sf = mkframe(6'd16, 32'h200, 8'hFF);
      end else begin
        init_d = ST_OK; do_csdi = 1'b1;
      end
    end
    if (do_app) begin
      do_start = 1'b1; sk = K_APP;
      sf = mkframe(6'd55, hc_d ? 32'h4000_0000 : 32'd0, 8'hFF);
    end
    if (do_csdi) begin
      do_start = 1'b1; sk = K_CSDI; sf = mkframe(6'd9, 32'd0, 8'hFF);
    end
    if (do_start) begin
      ctx_d = sk; frame_d = sf; bi_d = '0; phase_d = PH_CMD;
      res_o.mosi_byte = IDLE_BYTE; res_o.busy_res = 1'b1; res_o.cs_active = 1'b1;
    end
    if (do_fin) begin
      phase_d = PH_IDLE; res_o.mosi_byte = IDLE_BYTE; res_o.cs_active = 1'b0;
      res_o.busy_res = 1'b0; res_o.done_res = 1'b1; res_o.status = fcode;
    end
    res_o.card_is_hc = hc_d;
    res_o.sector_count = sect_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; ctx_q <= K_GOIDLE; try_q <= '0; poll_q <= '0; bi_q <= '0;
      frame_q <= '0; hc_q <= 1'b0; rech_q <= 1'b0; v2_q <= 1'b0; echo_q <= 1'b0;
      init_q <= ST_OK; sect_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; ctx_q <= ctx_d; try_q <= try_d; poll_q <= poll_d; bi_q <= bi_d;
      frame_q <= frame_d; hc_q <= hc_d; rech_q <= rech_d; v2_q <= v2_d; echo_q <= echo_d;
      init_q <= init_d; sect_q <= sect_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) csd_q <= csd_d;
  end

endmodule

// ===== hdl/sd_spi_init_and_block_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_init_and_block_sequencer
// SD card SPI-mode host sequencer: init, block read/write, CSD/CID read.
// ----------------------------------------------------------------------------
// Each input transfer carries the byte received in the last SPI exchange and
// yields one result transfer with the next MOSI byte and chip-select level.
// A transfer is processed combinationally by the sequencer logic and lands
// in an output register; a new input is taken every cycle the output register
// is empty or being drained, so the block sustains one byte per clock while
// the result side does not hold it off, and is otherwise paced by the SPI link.
module sd_spi_init_and_block_sequencer #(
  parameter int unsigned WAKE_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // block_addr[31:0], miso_byte[39:32], tx_data[47:40]
  input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mosi_byte[7:0], cs_active[8], busy_res[9], done_res[10], status[13:11],
  // rx_valid[14], rx_byte[22:15], need_tx_data[23], card_is_hc[24],
  // sector_count[56:25], zero[63:57]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,   // rx_last
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);
  import sdspi_pkg::*;

  cfg_t cfg_q;
  res_t res, out_q;
  logic rx_last, last_q, valid_q, step;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_retry  <= 8'd50;
      cfg_q.ready_retry <= 16'd30000;
      cfg_q.resp_poll   <= 8'd8;
      cfg_q.token_poll  <= 20'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDLE_RETRY:  cfg_q.idle_retry  <= cfg_wdata_i[7:0];
        CFG_READY_RETRY: cfg_q.ready_retry <= cfg_wdata_i[15:0];
        CFG_RESP_POLL:   cfg_q.resp_poll   <= cfg_wdata_i[7:0];
        CFG_TOKEN_POLL:  cfg_q.token_poll  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sdspi_core #(.WAKE_BYTES(WAKE_BYTES)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .opcode_i     (s_axis_tuser),
    .block_addr_i (s_axis_tdata[31:0]),
    .miso_i       (s_axis_tdata[39:32]),
    .tx_data_i    (s_axis_tdata[47:40]),
    .cfg_i        (cfg_q),
    .res_o        (res),
    .rx_last_o    (rx_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q  <= res;
      last_q <= rx_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {7'd0, out_q};
  assign m_axis_tlast  = last_q;

endmodule

// ===== verif/tb_sd_spi_init_and_block_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_spi_init_and_block_sequencer
// Self-checking testbench for the SD card SPI-mode sequencer.
// ----------------------------------------------------------------------------
// A card responder builds byte-slot transfers that follow the sequencer's
// progress, so init, block read/write and CSD/CID reads run to completion,
// with random refusals, timeouts and corrupt replies mixed in. A local
// sequencer model predicts every result transfer, and the monitor compares
// each field. Both stream sides idle at random; the limit registers are
// changed between phases, with a long result hold-off in one of them.
// ----------------------------------------------------------------------------
module tb_sd_spi_init_and_block_sequencer;
  import sdspi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned WAKE_COUNT  = 10;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_WAKE, SQ_SEL, SQ_CMD, SQ_POLL, SQ_TRAIL, SQ_TOKEN, SQ_RX, SQ_WDATA,
    SQ_WTAIL, SQ_BUSY
  } seq_phase_e;

  typedef enum logic [3:0] {
    CX_GOIDLE, CX_IFCOND, CX_OCR1, CX_APP, CX_OPCOND, CX_OCR2, CX_BLKLEN, CX_CSDI, CX_REG,
    CX_READ, CX_WRITE
  } cmd_ctx_e;

  typedef struct packed {
    seq_phase_e    ph;
    cmd_ctx_e      ctx;
    logic [15:0]   tries;
    logic [19:0]   polls;
    logic [9:0]    bidx;
    logic [47:0]   frame;
    logic [5:0][7:0] csd;
    logic          hc;
    logic          recheck;
    logic          v2;
    logic          echo;
    logic [2:0]    icode;
    logic [31:0]   sectors;
    logic [7:0]    lim_idle;
    logic [15:0]   lim_ready;
    logic [7:0]    lim_resp;
    logic [19:0]   lim_tok;
  } card_seq_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [7:0]  miso;
    logic [7:0]  tx;
  } slot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // block_addr[31:0], miso_byte[39:32], tx_data[47:40]
  logic [2:0]  s_axis_tuser = '0;   // opcode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // mosi_byte[7:0], cs_active[8], busy_res[9], done_res[10], status[13:11],
  // rx_valid[14], rx_byte[22:15], need_tx_data[23], card_is_hc[24],
  // sector_count[56:25], zero[63:57]
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;        // rx_last
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [19:0] cfg_wdata_i = '0;

  card_seq_t   chk_seq, gen_seq;
  slot_t       pending_slots[$];
  res_t        exp_res[$];
  logic        exp_last[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned slot_total = 0;
  bit          gaps_on = 1'b1;

  sd_spi_init_and_block_sequencer #(.WAKE_BYTES(WAKE_COUNT)) uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [47:0] cmd_frame(input logic [5:0] cmd, input logic [31:0] arg,
                                            input logic [7:0] crc);
    cmd_frame = {2'b01, cmd, arg, crc};
  endfunction

  function automatic int unsigned one_min(input int unsigned v);
    one_min = (v == 0) ? 1 : v;
  endfunction

  function automatic void emit(inout res_t r, input logic [7:0] b, input logic cs);
    r.mosi_byte = b;
    r.cs_active = cs;
    r.busy_res  = 1'b1;
  endfunction

  function automatic void finish_req(inout card_seq_t s, inout res_t r, input logic [2:0] code);
    r.mosi_byte = IDLE_BYTE;
    r.cs_active = 1'b0;
    r.busy_res  = 1'b0;
    r.done_res  = 1'b1;
    r.status    = code;
    s.ph        = SQ_IDLE;
  endfunction

  function automatic void start_cmd(inout card_seq_t s, inout res_t r, input cmd_ctx_e k,
                                    input logic [47:0] f);
    s.ctx   = k;
    s.frame = f;
    s.bidx  = '0;
    s.ph    = SQ_CMD;
    emit(r, IDLE_BYTE, 1'b1);
  endfunction

  function automatic void start_app(inout card_seq_t s, inout res_t r);
    start_cmd(s, r, CX_APP, cmd_frame(6'd55, s.hc ? 32'h4000_0000 : 32'd0, 8'hFF));
  endfunction

  function automatic void ocr_recheck(inout card_seq_t s, inout res_t r);
    if (s.recheck) begin
      if (s.tries >= one_min(s.lim_ready)) begin
        s.icode = ST_OCR_TO;
        start_cmd(s, r, CX_CSDI, cmd_frame(6'd9, 32'd0, 8'hFF));
      end else begin
        s.tries = s.tries + 16'd1;
        start_cmd(s, r, CX_OCR2, cmd_frame(6'd58, 32'd0, 8'hFF));
      end
    end else if (!s.hc) begin
      start_cmd(s, r, CX_BLKLEN, cmd_frame(6'd16, 32'h200, 8'hFF));
    end else begin
      s.icode = ST_OK;
      start_cmd(s, r, CX_CSDI, cmd_frame(6'd9, 32'd0, 8'hFF));
    end
  endfunction

  function automatic void begin_trail(inout card_seq_t s, inout res_t r);
    s.bidx = 10'd1;
    s.ph   = SQ_TRAIL;
    emit(r, IDLE_BYTE, 1'b1);
  endfunction

  function automatic void begin_token(inout card_seq_t s, inout res_t r);
    s.polls = 20'd1;
    s.ph    = SQ_TOKEN;
    emit(r, IDLE_BYTE, 1'b1);
  endfunction

  function automatic void dispatch(inout card_seq_t s, inout res_t r, input logic [7:0] rb);
    case (s.ctx)
      CX_GOIDLE: begin
        if (rb == 8'h01) begin
          start_cmd(s, r, CX_IFCOND, cmd_frame(6'd8, 32'h1AA, 8'h87));
        end else begin
          s.tries = s.tries + 16'd1;
          if (s.tries >= one_min(s.lim_idle)) begin
            s.icode = ST_NO_IDLE;
            start_cmd(s, r, CX_CSDI, cmd_frame(6'd9, 32'd0, 8'hFF));
          end else begin
            start_cmd(s, r, CX_GOIDLE, cmd_frame(6'd0, 32'd0, 8'h95));
          end
        end
      end
      CX_IFCOND: begin
        if (!rb[2]) begin
          s.echo = 1'b1;
          begin_trail(s, r);
        end else begin
          s.hc = 1'b0;
          s.recheck = 1'b0;
          start_cmd(s, r, CX_OCR1, cmd_frame(6'd58, 32'd0, 8'hFF));
        end
      end
      CX_OCR1, CX_OCR2: begin_trail(s, r);
      CX_APP: start_cmd(s, r, CX_OPCOND, cmd_frame(6'd41, 32'h4000_0000, 8'hFF));
      CX_OPCOND: begin
        if (!rb[0]) begin
          ocr_recheck(s, r);
        end else begin
          s.tries = s.tries + 16'd1;
          if (s.tries >= one_min(s.lim_ready)) begin
            s.icode = ST_INIT_TO;
            start_cmd(s, r, CX_CSDI, cmd_frame(6'd9, 32'd0, 8'hFF));
          end else begin
            start_app(s, r);
          end
        end
      end
      CX_BLKLEN: begin
        s.icode = ST_OK;
        start_cmd(s, r, CX_CSDI, cmd_frame(6'd9, 32'd0, 8'hFF));
      end
      CX_CSDI: begin
        if (rb != 0) begin
          s.sectors = '0;
          finish_req(s, r, s.icode);
        end else begin
          begin_token(s, r);
        end
      end
      CX_WRITE: begin
        if (rb != 0) begin
          finish_req(s, r, ST_REJECT);
        end else begin
          s.bidx = '0;
          s.ph   = SQ_WDATA;
          emit(r, TOKEN_START, 1'b1);
          r.need_tx_data = 1'b1;
        end
      end
      default: begin
        if (rb != 0) finish_req(s, r, ST_REJECT);
        else begin_token(s, r);
      end
    endcase
  endfunction

  function automatic void take_trail(inout card_seq_t s, inout res_t r, input logic [7:0] b);
    int unsigned j;
    j = s.bidx - 1;
    if (s.ctx == CX_IFCOND) begin
      if (j == 2 && !b[0]) s.echo = 1'b0;
      if (j == 3 && b != 8'hAA) s.echo = 1'b0;
    end else if (s.ctx == CX_OCR1 && j == 0) begin
      if (b[7]) begin
        s.hc = b[6];
        s.recheck = 1'b0;
      end else begin
        s.recheck = 1'b1;
      end
    end else if (s.ctx == CX_OCR2 && j == 0) begin
      s.hc = b[6];
      s.recheck = !b[7];
    end
    if (s.bidx < 4) begin
      s.bidx = s.bidx + 10'd1;
      emit(r, IDLE_BYTE, 1'b1);
    end else if (s.ctx == CX_IFCOND) begin
      if (s.echo) begin
        s.hc = 1'b0;
        s.recheck = 1'b0;
        start_cmd(s, r, CX_OCR1, cmd_frame(6'd58, 32'd0, 8'hFF));
      end else begin
        s.icode = ST_VOLTAGE;
        start_cmd(s, r, CX_CSDI, cmd_frame(6'd9, 32'd0, 8'hFF));
      end
    end else if (s.ctx == CX_OCR1) begin
      s.tries = '0;
      start_app(s, r);
    end else begin
      ocr_recheck(s, r);
    end
  endfunction

  function automatic logic [31:0] capacity(input card_seq_t s);
    logic [63:0] n;
    logic [31:0] size;
    int unsigned mult;
    if (s.v2) begin
      n = {42'd0, s.csd[2][5:0], s.csd[3], s.csd[4]};
      n = (n + 64'd1) << 10;
      capacity = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
    end else begin
      size = {20'd0, s.csd[1][1:0], s.csd[2], s.csd[3][7:6]} + 32'd1;
      mult = {s.csd[4][1:0], s.csd[5][7]} + 2 + s.csd[0][3:0];
      capacity = (mult >= 9) ? (size << (mult - 9)) : (size >> (9 - mult));
    end
  endfunction

  function automatic void take_rx(inout card_seq_t s, inout res_t r, inout logic last,
                                  input logic [7:0] b);
    int unsigned j, payload;
    j = s.bidx - 1;
    payload = (s.ctx == CX_READ) ? BLOCK_BYTES : REG_BYTES;
    if (s.ctx == CX_CSDI) begin
      if (j == 0) s.v2 = b[6];
      if (j >= 5 && j <= 10) s.csd[j - 5] = b;
    end else if (j < payload) begin
      r.rx_valid = 1'b1;
      r.rx_byte  = b;
      last = (j == payload - 1);
    end
    if (s.bidx < payload + 2) begin
      s.bidx = s.bidx + 10'd1;
      emit(r, IDLE_BYTE, 1'b1);
    end else if (s.ctx == CX_CSDI) begin
      s.sectors = capacity(s);
      finish_req(s, r, s.icode);
    end else begin
      finish_req(s, r, ST_OK);
    end
  endfunction

  function automatic void seq_step(inout card_seq_t s, input slot_t in, output res_t r,
                                   output logic last);
    logic [31:0] addr;
    r = '0;
    r.mosi_byte = IDLE_BYTE;
    last = 1'b0;
    case (s.ph)
      SQ_IDLE: begin
        addr = s.hc ? in.addr : (in.addr << 9);
        case (in.op)
          OP_INIT: begin
            s.icode = ST_OK;
            s.tries = '0;
            s.ctx   = CX_GOIDLE;
            s.frame = cmd_frame(6'd0, 32'd0, 8'h95);
            s.bidx  = '0;
            s.ph    = SQ_WAKE;
            emit(r, IDLE_BYTE, 1'b0);
          end
          OP_READ, OP_WRITE: begin
            s.ctx   = (in.op == OP_READ) ? CX_READ : CX_WRITE;
            s.frame = cmd_frame((in.op == OP_READ) ? 6'd17 : 6'd24, addr, 8'hFF);
            s.ph    = SQ_SEL;
            emit(r, IDLE_BYTE, 1'b1);
          end
          OP_CSD, OP_CID: begin
            s.ctx   = CX_REG;
            s.frame = cmd_frame((in.op == OP_CSD) ? 6'd9 : 6'd10, 32'd0, 8'hFF);
            s.ph    = SQ_SEL;
            emit(r, IDLE_BYTE, 1'b1);
          end
          default: ;
        endcase
      end
      SQ_WAKE: begin
        if (s.bidx < WAKE_COUNT) begin
          s.bidx = s.bidx + 10'd1;
          emit(r, IDLE_BYTE, 1'b0);
        end else begin
          s.ph = SQ_SEL;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      SQ_SEL: start_cmd(s, r, s.ctx, s.frame);
      SQ_CMD: begin
        if (s.bidx < 6) begin
          emit(r, s.frame[(40 - 8 * s.bidx) +: 8], 1'b1);
          s.bidx = s.bidx + 10'd1;
        end else begin
          s.polls = 20'd1;
          s.ph = SQ_POLL;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      SQ_POLL: begin
        if (in.miso != 8'hFF || s.polls >= one_min(s.lim_resp)) begin
          dispatch(s, r, in.miso);
        end else begin
          s.polls = s.polls + 20'd1;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      SQ_TRAIL: take_trail(s, r, in.miso);
      SQ_TOKEN: begin
        if (in.miso == TOKEN_START) begin
          s.bidx = 10'd1;
          s.ph = SQ_RX;
          emit(r, IDLE_BYTE, 1'b1);
        end else if (s.lim_tok != 0 && s.polls >= s.lim_tok) begin
          if (s.ctx == CX_CSDI) begin
            s.sectors = '0;
            finish_req(s, r, (s.icode != ST_OK) ? s.icode : ST_TOKEN_TO);
          end else begin
            finish_req(s, r, ST_TOKEN_TO);
          end
        end else begin
          s.polls = s.polls + 20'd1;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      SQ_RX: take_rx(s, r, last, in.miso);
      SQ_WDATA: begin
        if (s.bidx < BLOCK_BYTES) begin
          s.bidx = s.bidx + 10'd1;
          emit(r, in.tx, 1'b1);
          r.need_tx_data = (s.bidx < BLOCK_BYTES);
        end else begin
          s.bidx = 10'd1;
          s.ph = SQ_WTAIL;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      SQ_WTAIL: begin
        if (s.bidx < TAIL_BYTES) begin
          s.bidx = s.bidx + 10'd1;
          emit(r, IDLE_BYTE, 1'b1);
        end else begin
          s.polls = 20'd1;
          s.ph = SQ_BUSY;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      SQ_BUSY: begin
        if (in.miso == 8'hFF) finish_req(s, r, ST_OK);
        else if (s.lim_tok != 0 && s.polls >= s.lim_tok) finish_req(s, r, ST_TOKEN_TO);
        else begin
          s.polls = s.polls + 20'd1;
          emit(r, IDLE_BYTE, 1'b1);
        end
      end
      default: s.ph = SQ_IDLE;
    endcase
    r.card_is_hc   = s.hc;
    r.sector_count = s.sectors;
  endfunction

  // Card side: reply bytes that mostly keep the sequence going.
  function automatic logic [7:0] card_reply(input card_seq_t s);
    int unsigned j;
    logic [7:0] b;
    j = s.bidx - 1;
    b = 8'($urandom);
    case (s.ph)
      SQ_POLL: begin
        if ($urandom_range(0, 3) == 0) b = 8'hFF;
        else begin
          case (s.ctx)
            CX_GOIDLE: if ($urandom_range(0, 7) != 0) b = 8'h01;
            CX_IFCOND: b = ($urandom_range(0, 3) == 0) ? 8'h05 : 8'h01;
            CX_OCR1, CX_OCR2, CX_APP: b = 8'h01;
            CX_OPCOND: b = 8'($urandom_range(0, 1));
            CX_BLKLEN: b = 8'h00;
            default: if ($urandom_range(0, 9) != 0) b = 8'h00;
          endcase
        end
      end
      SQ_TRAIL: begin
        if (s.ctx == CX_IFCOND && j == 2 && $urandom_range(0, 7) != 0) b = 8'h01;
        if (s.ctx == CX_IFCOND && j == 3 && $urandom_range(0, 7) != 0) b = 8'hAA;
        if (s.ctx != CX_IFCOND && j == 0) b[7] = ($urandom_range(0, 4) != 0);
      end
      SQ_TOKEN: if ($urandom_range(0, 3) == 0) b = TOKEN_START;
                else if ($urandom_range(0, 1) == 0) b = 8'hFF;
      SQ_BUSY: b = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'h00;
      default: ;
    endcase
    card_reply = b;
  endfunction

  task automatic add_slot(input slot_t it);
    res_t r;
    logic l;
    seq_step(gen_seq, it, r, l);
    pending_slots.push_back(it);
    slot_total = slot_total + 1;
  endtask

  task automatic add_request();
    slot_t it;
    int unsigned w;
    w = $urandom_range(0, 19);
    it.op   = (w < 2) ? ((w == 0) ? OP_SLOT : 3'($urandom_range(6, 7))) :
              (w < 7) ? OP_INIT : 3'($urandom_range(2, 5));
    it.addr = $urandom;
    it.miso = 8'($urandom);
    it.tx   = 8'($urandom);
    add_slot(it);
    while (gen_seq.ph != SQ_IDLE) begin
      it.op   = 3'($urandom);
      it.addr = $urandom;
      it.miso = card_reply(gen_seq);
      it.tx   = 8'($urandom);
      add_slot(it);
    end
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_IDLE_RETRY:  begin chk_seq.lim_idle  = val[7:0];  gen_seq.lim_idle  = val[7:0];  end
      CFG_READY_RETRY: begin chk_seq.lim_ready = val[15:0]; gen_seq.lim_ready = val[15:0]; end
      CFG_RESP_POLL:   begin chk_seq.lim_resp  = val[7:0];  gen_seq.lim_resp  = val[7:0];  end
      default:         begin chk_seq.lim_tok   = val;       gen_seq.lim_tok   = val;       end
    endcase
  endtask

  task automatic set_limits(input logic [7:0] li, input logic [15:0] lr, input logic [7:0] lp,
                            input logic [19:0] lt);
    write_cfg(CFG_IDLE_RETRY, {12'd0, li});
    write_cfg(CFG_READY_RETRY, {4'd0, lr});
    write_cfg(CFG_RESP_POLL, {12'd0, lp});
    write_cfg(CFG_TOKEN_POLL, lt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_slots.size() != 0 || s_axis_tvalid || exp_res.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // Input side
  always @(posedge clk_i or negedge rst_ni) begin
    res_t r;
    logic l;
    slot_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.op   = s_axis_tuser;
        it.addr = s_axis_tdata[31:0];
        it.miso = s_axis_tdata[39:32];
        it.tx   = s_axis_tdata[47:40];
        seq_step(chk_seq, it, r, l);
        exp_res.push_back(r);
        exp_last.push_back(l);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_slots.size() != 0) begin
          it = pending_slots.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.op;
          s_axis_tdata  <= {it.tx, it.miso, it.addr};
          if (gaps_on && $urandom_range(0, 3) == 0)
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                        $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e, got;
    logic el;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[56:0];
        if (exp_res.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10) $display("unexpected result transfer: %h", m_axis_tdata);
        end else begin
          e  = exp_res.pop_front();
          el = exp_last.pop_front();
          if (got.mosi_byte !== e.mosi_byte || got.cs_active !== e.cs_active ||
              got.busy_res !== e.busy_res || got.done_res !== e.done_res ||
              got.status !== e.status || got.rx_valid !== e.rx_valid ||
              got.rx_byte !== e.rx_byte || got.need_tx_data !== e.need_tx_data ||
              got.card_is_hc !== e.card_is_hc || got.sector_count !== e.sector_count ||
              m_axis_tlast !== el || m_axis_tdata[63:57] !== 7'd0) begin
            err_count <= err_count + 1;
            if (err_count < 10)
              $display("mismatch: exp %h last %b, got %h last %b", {7'd0, e}, el,
                       m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        stall_left <= 400;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                      $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sd_spi_init_and_block_sequencer");
      $finish;
    end
  end

  initial begin
    slot_t it;
    chk_seq = '0;
    chk_seq.ph = SQ_IDLE;
    chk_seq.ctx = CX_GOIDLE;
    chk_seq.lim_idle = 8'd50;
    chk_seq.lim_ready = 16'd30000;
    chk_seq.lim_resp = 8'd8;
    gen_seq = chk_seq;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_limits(8'd50, 16'd30000, 8'd8, 20'd0);
        1: set_limits(8'd1, 16'd1, 8'd1, 20'd1);
        2: set_limits(8'd255, 16'd65535, 8'd255, 20'hFFFFF);
        3: set_limits(8'd3, 16'd4, 8'd2, 20'd0);
        4: set_limits(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                      8'($urandom_range(1, 255)), 20'($urandom_range(0, 1048575)));
        default: set_limits(8'd2, 16'd3, 8'd1, 20'd5);
      endcase
      gaps_on = (p != 3);
      if (p == 0) begin
        // ignored opcodes at the field extremes, then a CSD read before init
        for (int k = 0; k < 6; k++) begin
          it.op   = (k % 3 == 0) ? OP_SLOT : ((k % 3 == 1) ? 3'd6 : 3'd7);
          it.addr = (k < 3) ? 32'd0 : 32'hFFFF_FFFF;
          it.miso = (k < 3) ? 8'h00 : 8'hFF;
          it.tx   = (k < 3) ? 8'hFF : 8'h00;
          add_slot(it);
        end
        it = '{op: OP_CSD, addr: 32'hFFFF_FFFF, miso: 8'h00, tx: 8'hFF};
        add_slot(it);
        while (gen_seq.ph != SQ_IDLE) begin
          it.op = OP_INIT;
          it.miso = card_reply(gen_seq);
          add_slot(it);
        end
      end
      if (p == 2) hold_req = hold_req + 1;
      do add_request(); while (slot_total < (p + 1) * 150);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS sd_spi_init_and_block_sequencer");
    end else begin
      $display("FAIL sd_spi_init_and_block_sequencer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sdspi_pkg.sv
hdl/sdspi_core.sv
hdl/sd_spi_init_and_block_sequencer.sv
verif/tb_sd_spi_init_and_block_sequencer.sv
